### rtl/vmif_pkg.sv
package vmif_pkg;

  localparam int CoordW  = 32;
  localparam int VoxelW  = 31;
  localparam int DecW    = 2;
  localparam int NumAxes = 3;

  // Doubled voxel centre and its distance to a doubled neighbour coordinate
  localparam int CentreW = CoordW + 3;
  localparam int DistW   = CentreW;
  localparam int DiffW   = DistW + 1;

  // 1.732 voxel sizes as the exact ratio 3464 / 1000 on doubled distances
  localparam int DistScale = 1000;
  localparam int FarScale  = 3464;
  localparam int ProdW     = DistW + 10;

  localparam logic [VoxelW-1:0] VoxelReset = VoxelW'(32768);

  localparam logic ModeQuery = 1'b0;
  localparam logic ModeNbr   = 1'b1;

  localparam logic [DecW-1:0] DecDown = 2'd0;
  localparam logic [DecW-1:0] DecAdd  = 2'd1;
  localparam logic [DecW-1:0] DecSkip = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [CoordW-1:0] coord_z;
    logic              last_in_group;
  } vmif_in_t;

  typedef struct packed {
    logic [DecW-1:0]   decision;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [CoordW-1:0] point_z;
  } vmif_out_t;

  typedef struct packed {
    logic              done;
    logic [VoxelW-1:0] rem;
  } vmif_rem_stat_t;

  typedef struct packed {
    logic far;
    logic in_vox;
  } vmif_chk_t;

endpackage

### rtl/vmif_rem.sv
module vmif_rem import vmif_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CoordW-1:0] dividend_i,
  input  logic [VoxelW-1:0] divisor_i,
  output vmif_rem_stat_t    stat_o
);

  localparam int CntW = $clog2(CoordW);

  logic            run_q;
  logic [CntW-1:0] cnt_q;
  logic [CoordW-1:0] dvd_q;
  logic [VoxelW-1:0] div_q;
  logic [VoxelW-1:0] rem_q;

  logic [VoxelW:0] trial;
  logic [VoxelW:0] rem_next;

  // Restoring remainder: bring down one dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_q, dvd_q[CoordW-1]};
    rem_next = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CntW'(CoordW - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[CoordW-2:0], 1'b0};
      rem_q <= rem_next[VoxelW-1:0];
    end
  end

  assign stat_o.done = run_q && (cnt_q == '0);
  assign stat_o.rem  = rem_q;

endmodule

### rtl/vmif_axis_chk.sv
module vmif_axis_chk import vmif_pkg::*; (
  input  logic [DistW-1:0]  dist_i,
  input  logic [VoxelW-1:0] voxel_i,
  output vmif_chk_t         chk_o
);

  logic [ProdW-1:0] lhs;
  logic [ProdW-1:0] rhs;

  // Far: |n - c| > 1.732 v, on doubled distances. Inside: |n - c| < v / 2.
  always_comb begin
    lhs          = ProdW'(dist_i) * ProdW'(DistScale);
    rhs          = ProdW'(voxel_i) * ProdW'(FarScale);
    chk_o.far    = lhs > rhs;
    chk_o.in_vox = dist_i < DistW'(voxel_i);
  end

endmodule

### rtl/voxel_map_insert_filter_top.sv
// Voxel map insert filter. A group is one query point beat (mode 0) followed by
// zero or more neighbour beats (mode 1); the beat with last_in_group set ends the
// group and yields one result beat: decision (0 add downsampled, 1 add without
// downsampling, 2 skip) and the stored query point. A query beat finds, per axis,
// twice the centre of the voxel holding the point, using one shared restoring
// remainder unit that retires one bit a cycle. A neighbour beat takes, per axis,
// a distance step, then a threshold compare. A beat that ends its group then
// loads the output register, and waits there while an earlier result is still
// held. The input side is ready only while the sequencer is idle; the output
// register lets the next beat enter while a result waits. A voxel size of zero
// acts as one. The configuration port is always ready; write it only while the
// block is idle.
module voxel_map_insert_filter_top import vmif_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vmif_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vmif_out_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [VoxelW-1:0] cfg_data_i
);

  // Sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;  // start the remainder unit on this axis
  localparam logic [2:0] StRem  = 3'd2;  // wait for the remainder
  localparam logic [2:0] StCtr  = 3'd3;  // form the doubled centre
  localparam logic [2:0] StDiff = 3'd4;  // doubled distance to the centre
  localparam logic [2:0] StCmp  = 3'd5;  // threshold checks, verdict update
  localparam logic [2:0] StEmit = 3'd6;  // load the output register

  localparam logic [1:0] LastAxis = 2'(NumAxes - 1);

  logic [2:0] state_q, state_d;
  logic [1:0] ax_q;
  logic       last_q;

  logic signed [CoordW-1:0]  coord_q  [NumAxes];
  logic        [CoordW-1:0]  query_q  [NumAxes];
  logic signed [CentreW-1:0] centre_q [NumAxes];

  logic [VoxelW-1:0] voxel_q;
  logic [VoxelW-1:0] veff;

  logic            seen_q;
  logic            locked_q;
  logic [DecW-1:0] verdict_q;
  logic            far_acc_q;
  logic            in_acc_q;
  logic [DistW-1:0] dist_q;

  logic      out_valid_q;
  vmif_out_t out_q;

  logic accept;
  logic emit_ok;
  logic rem_start;

  logic signed [CoordW-1:0]  cur_coord;
  logic                      cur_neg;
  logic        [CoordW-1:0]  cur_mag;
  logic        [VoxelW-1:0]  floor_r;
  logic signed [CoordW:0]    base;
  logic signed [CentreW-1:0] centre_new;
  logic signed [DiffW-1:0]   diff;
  logic        [DiffW-1:0]   diff_abs;

  logic far_all;
  logic in_all;

  vmif_rem_stat_t rem_stat;
  vmif_chk_t      chk;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign emit_ok     = !out_valid_q || out_ready_i;
  assign rem_start   = (state_q == StLoad);

  assign veff = (voxel_q == '0) ? VoxelW'(1) : voxel_q;

  // Per-axis operand selection
  assign cur_coord = coord_q[ax_q];
  assign cur_neg   = cur_coord[CoordW-1];
  assign cur_mag   = cur_neg ? (~cur_coord + CoordW'(1)) : cur_coord;

  vmif_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (cur_mag),
    .divisor_i  (veff),
    .stat_o     (rem_stat)
  );

  // Floor toward minus infinity: a negative coordinate with a non-zero
  // remainder of its magnitude lies v - r above the voxel's lower edge.
  // Doubled centre = 2 * (c - r) + v, kept exact.
  always_comb begin
    floor_r    = (cur_neg && (rem_stat.rem != '0)) ? (veff - rem_stat.rem) : rem_stat.rem;
    base       = $signed({cur_coord[CoordW-1], cur_coord})
               - $signed({2'b00, floor_r});
    centre_new = $signed({base[CoordW], base, 1'b0})
               + $signed({{(CentreW - VoxelW){1'b0}}, veff});
  end

  // Doubled distance of the neighbour from the centre on the current axis
  always_comb begin
    diff     = $signed({{(DiffW - CoordW - 1){cur_coord[CoordW-1]}}, cur_coord, 1'b0})
             - $signed({centre_q[ax_q][CentreW-1], centre_q[ax_q]});
    diff_abs = diff[DiffW-1] ? (~diff + DiffW'(1)) : diff;
  end

  vmif_axis_chk u_chk (
    .dist_i  (dist_q),
    .voxel_i (veff),
    .chk_o   (chk)
  );

  assign far_all = far_acc_q | chk.far;
  assign in_all  = in_acc_q & chk.in_vox;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = (in_data_i.mode == ModeNbr) ? StDiff : StLoad;
        end
      end
      StLoad: state_d = StRem;
      StRem: begin
        if (rem_stat.done) begin
          state_d = StCtr;
        end
      end
      StCtr: begin
        if (ax_q == LastAxis) begin
          state_d = last_q ? StEmit : StIdle;
        end else begin
          state_d = StLoad;
        end
      end
      StDiff: state_d = StCmp;
      StCmp: begin
        if (ax_q == LastAxis) begin
          state_d = last_q ? StEmit : StIdle;
        end else begin
          state_d = StDiff;
        end
      end
      StEmit: begin
        if (emit_ok) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      voxel_q     <= VoxelReset;
      seen_q      <= 1'b0;
      locked_q    <= 1'b0;
      verdict_q   <= DecDown;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        query_q[i]  <= '0;
        centre_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        voxel_q <= cfg_data_i;
      end

      // A query opens a fresh group; an unfinished one is dropped.
      if (accept && (in_data_i.mode == ModeQuery)) begin
        query_q[0] <= in_data_i.coord_x;
        query_q[1] <= in_data_i.coord_y;
        query_q[2] <= in_data_i.coord_z;
        seen_q     <= 1'b0;
        locked_q   <= 1'b0;
        verdict_q  <= DecDown;
      end

      if (state_q == StCtr) begin
        centre_q[ax_q] <= centre_new;
      end

      // Verdict: first neighbour far away on any axis locks "add",
      // otherwise a neighbour inside the voxel locks "skip".
      if ((state_q == StCmp) && (ax_q == LastAxis)) begin
        seen_q <= 1'b1;
        if (!locked_q && !seen_q && far_all) begin
          verdict_q <= DecAdd;
          locked_q  <= 1'b1;
        end else if (!locked_q && in_all) begin
          verdict_q <= DecSkip;
          locked_q  <= 1'b1;
        end
      end

      // Hand the result over and clear the group
      if ((state_q == StEmit) && emit_ok) begin
        out_valid_q <= 1'b1;
        seen_q      <= 1'b0;
        locked_q    <= 1'b0;
        verdict_q   <= DecDown;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      coord_q[0] <= in_data_i.coord_x;
      coord_q[1] <= in_data_i.coord_y;
      coord_q[2] <= in_data_i.coord_z;
      last_q     <= in_data_i.last_in_group;
      ax_q       <= '0;
      far_acc_q  <= 1'b0;
      in_acc_q   <= 1'b1;
    end else if ((state_q == StCtr) || (state_q == StCmp)) begin
      ax_q <= ax_q + 1'b1;
    end

    if (state_q == StDiff) begin
      dist_q <= diff_abs[DistW-1:0];
    end

    if (state_q == StCmp) begin
      far_acc_q <= far_all;
      in_acc_q  <= in_all;
    end

    if ((state_q == StEmit) && emit_ok) begin
      out_q.decision <= seen_q ? verdict_q : DecAdd;
      out_q.point_x  <= query_q[0];
      out_q.point_y  <= query_q[1];
      out_q.point_z  <= query_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vmif_pkg::*;

  localparam int Gap          = 12;        // longest idle drawn per beat, either side
  localparam int CycleLimit   = 1_000_000;
  localparam int DrainCycles  = 150;       // lets a query beat that is still running finish
  localparam int PressureAt   = 30;        // result count at which the long back-pressure starts
  localparam int PressureHold = 800;
  localparam int MaxReports   = 10;
  localparam int DirRows      = 20;
  localparam int NumPhases    = 7;
  localparam int RandItems    = 1080;
  localparam int OwedDepth    = 16;

  // One row of the directed table: the beat, and where the result is obvious, the result
  typedef struct packed {
    vmif_in_t  beat;
    logic      typed;
    vmif_out_t res;
  } row_t;

  // Where a generated neighbour lands relative to the voxel centre
  typedef enum logic [2:0] {
    NbrInside, NbrNear, NbrFarEdge, NbrOnQuery, NbrWide, NbrAny
  } nbr_place_e;

  // Shape of a generated group
  typedef enum logic [2:0] {
    GrpLone, GrpNormal, GrpTrailing, GrpAbandon, GrpNoise
  } grp_shape_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  vmif_in_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  vmif_out_t         out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [VoxelW-1:0] cfg_data_i  = '0;

  // Shadow of the filter: register copy and group state
  logic [VoxelW-1:0] voxel_reg = VoxelReset;
  logic [CoordW-1:0] held_pt [NumAxes];
  longint            centre2 [NumAxes];   // twice the voxel centre, exact
  bit                nbr_seen;
  bit                verdict_locked;
  logic [DecW-1:0]   verdict;

  // Decisions still owed by the block, oldest at the read count
  vmif_out_t owed [OwedDepth];
  int        owed_wr    = 0;
  int        owed_rd    = 0;

  int        n_bad      = 0;
  int        n_results  = 0;
  int        cycles     = 0;
  int        rx_wait    = 0;
  int        rx_hold;
  bit        rx_burst   = 1'b0;
  bit        tx_burst   = 1'b0;
  vmif_out_t rx_want;

  // Directed beats, run with the voxel size at its reset value of half a metre
  row_t dir_tab [DirRows] = '{
    // neighbour before any query: judged against the zero centre, sits on it
    '{'{ModeNbr,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1,
      '{DecSkip, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
    // query that ends its own group, coordinate extremes
    '{'{ModeQuery, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1}, 1'b1,
      '{DecAdd, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}},
    // most negative query, most positive neighbour: far on the first neighbour
    '{'{ModeQuery, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
    // neighbour exactly half a voxel off the centre: not inside
    '{'{ModeQuery, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b0, '0},
    // first neighbour just past 1.732 voxels locks the verdict despite a later hit
    '{'{ModeQuery, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h0001_1DB3, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 1'b1}, 1'b0, '0},
    // first neighbour just short of 1.732 voxels, a later one dead centre
    '{'{ModeQuery, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h0001_1DB2, 32'h0000_4000, 32'h0000_4000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 1'b1}, 1'b0, '0},
    // negative coordinates: floor toward minus infinity, on and off voxel edges
    '{'{ModeQuery, 32'hFFFF_FFFF, 32'hFFFF_8000, 32'hFFFF_7FFF, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'hFFFF_C000, 32'hFFFF_C000, 32'hFFFF_4000, 1'b1}, 1'b0, '0},
    // new query arrives mid-group: the open group is dropped
    '{'{ModeQuery, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0}, 1'b0, '0},
    '{'{ModeQuery, 32'h0005_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{ModeNbr,   32'h0005_4000, 32'h0000_4000, 32'h0000_4000, 1'b1}, 1'b0, '0},
    // neighbours after a finished group form a new group for the same query
    '{'{ModeNbr,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b0, '0},
    '{'{ModeNbr,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0}
  };

  voxel_map_insert_filter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // A zero register acts as the smallest step
  function automatic longint voxel_eff();
    return (voxel_reg == '0) ? 64'sd1 : longint'(voxel_reg);
  endfunction

  // Twice the centre of the voxel holding c, floor toward minus infinity
  function automatic longint twice_centre(longint c, longint v);
    longint q;
    q = c / v;
    if ((c % v) != 0 && c < 0) q = q - 1;
    return 2 * q * v + v;
  endfunction

  // Advance the shadow filter by one accepted beat; return 1 when it yields a decision
  function automatic bit filter_step(input vmif_in_t b, output vmif_out_t res);
    longint v;
    longint c [NumAxes];
    longint d [NumAxes];
    v    = voxel_eff();
    c[0] = longint'($signed(b.coord_x));
    c[1] = longint'($signed(b.coord_y));
    c[2] = longint'($signed(b.coord_z));
    if (b.mode == ModeQuery) begin
      held_pt[0] = b.coord_x;
      held_pt[1] = b.coord_y;
      held_pt[2] = b.coord_z;
      for (int i = 0; i < NumAxes; i++) centre2[i] = twice_centre(c[i], v);
      nbr_seen       = 1'b0;
      verdict        = DecDown;
      verdict_locked = 1'b0;
    end else begin
      for (int i = 0; i < NumAxes; i++) begin
        d[i] = 2 * c[i] - centre2[i];
        if (d[i] < 0) d[i] = -d[i];
      end
      // only the first neighbour of a group is tested for being far off
      if (!verdict_locked && !nbr_seen) begin
        for (int i = 0; i < NumAxes; i++) begin
          if (DistScale * d[i] > FarScale * v) begin
            verdict        = DecAdd;
            verdict_locked = 1'b1;
          end
        end
      end
      if (!verdict_locked && d[0] < v && d[1] < v && d[2] < v) begin
        verdict        = DecSkip;
        verdict_locked = 1'b1;
      end
      nbr_seen = 1'b1;
    end
    res = '0;
    if (!b.last_in_group) return 1'b0;
    res.decision   = nbr_seen ? verdict : DecAdd;
    res.point_x    = held_pt[0];
    res.point_y    = held_pt[1];
    res.point_z    = held_pt[2];
    nbr_seen       = 1'b0;
    verdict        = DecDown;
    verdict_locked = 1'b0;
    return 1'b1;
  endfunction

  // Uniform in [-m, m]
  function automatic longint span_rand(longint m);
    bit [63:0]       r;
    longint unsigned w;
    r = {$urandom(), $urandom()};
    w = 2 * m + 1;
    return longint'(r % w) - m;
  endfunction

  function automatic vmif_in_t make_query(bit last);
    vmif_in_t          b;
    logic [CoordW-1:0] p [NumAxes];
    for (int i = 0; i < NumAxes; i++)
      p[i] = $urandom_range(0, 1) ? $urandom() : CoordW'(span_rand(4 * voxel_eff()));
    b.mode          = ModeQuery;
    b.coord_x       = p[0];
    b.coord_y       = p[1];
    b.coord_z       = p[2];
    b.last_in_group = last;
    return b;
  endfunction

  // Place a neighbour around the stored centre so that every verdict is reachable
  function automatic vmif_in_t make_nbr(bit last);
    vmif_in_t          b;
    logic [CoordW-1:0] p [NumAxes];
    nbr_place_e        place;
    int                r;
    int                far_axis;
    longint            v;
    longint            off;
    v        = voxel_eff();
    r        = int'($urandom_range(0, 9));
    far_axis = int'($urandom_range(0, NumAxes - 1));
    place    = (r < 3) ? NbrInside : (r < 5) ? NbrNear : (r < 6) ? NbrFarEdge :
               (r < 7) ? NbrOnQuery : (r < 9) ? NbrWide : NbrAny;
    for (int i = 0; i < NumAxes; i++) begin
      case (place)
        NbrInside: off = span_rand(v / 2);
        NbrNear:   off = span_rand(2 * v);
        NbrFarEdge: begin
          if (i == far_axis) begin
            off = (v * FarScale) / (2 * DistScale) + span_rand(1);
            if ($urandom_range(0, 1)) off = -off;
          end else begin
            off = span_rand(v / 2);
          end
        end
        NbrWide:   off = span_rand(8 * v);
        default:   off = 0;
      endcase
      case (place)
        NbrOnQuery: p[i] = held_pt[i];
        NbrAny:     p[i] = $urandom();
        default:    p[i] = CoordW'((centre2[i] >>> 1) + off);
      endcase
    end
    b.mode          = ModeNbr;
    b.coord_x       = p[0];
    b.coord_y       = p[1];
    b.coord_z       = p[2];
    b.last_in_group = last;
    return b;
  endfunction

  function automatic vmif_in_t make_noise();
    vmif_in_t b;
    b.mode          = 1'($urandom_range(0, 1));
    b.coord_x       = $urandom();
    b.coord_y       = $urandom();
    b.coord_z       = $urandom();
    b.last_in_group = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Offer one beat after a random gap, hold it until taken, then predict from it
  task automatic send_beat(input vmif_in_t b, input bit typed, input vmif_out_t typed_res);
    int        gap;
    vmif_out_t res;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : int'($urandom_range(0, Gap));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (filter_step(b, res)) begin
      owed[owed_wr % OwedDepth] = typed ? typed_res : res;
      owed_wr = owed_wr + 1;
    end
  endtask

  // Stop offering, collect every owed decision, then let any result-less query finish
  task automatic drain();
    in_valid_i <= 1'b0;
    while (owed_wr != owed_rd) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_voxel(input logic [VoxelW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    voxel_reg = val;
  endtask

  // Mostly well-formed groups with random content, some broken groups and noise
  task automatic run_phase(input int n_items);
    int         sent;
    int         k;
    int         r;
    grp_shape_e shape;
    // close the group left open before the register write: old centre, new thresholds
    k = int'($urandom_range(1, 3));
    for (int j = 0; j < k; j++) send_beat(make_nbr(j == k - 1), 1'b0, '0);
    sent = k;
    while (sent < n_items) begin
      r     = int'($urandom_range(0, 19));
      shape = (r < 2) ? GrpLone : (r < 14) ? GrpNormal : (r < 16) ? GrpTrailing :
              (r < 18) ? GrpAbandon : GrpNoise;
      case (shape)
        GrpLone: begin
          send_beat(make_query(1'b1), 1'b0, '0);
          sent++;
        end
        GrpNoise: begin
          k = int'($urandom_range(1, 3));
          for (int j = 0; j < k; j++) send_beat(make_noise(), 1'b0, '0);
          sent += k;
        end
        default: begin
          send_beat(make_query(1'b0), 1'b0, '0);
          k = int'($urandom_range(1, 4));
          for (int j = 0; j < k; j++)
            send_beat(make_nbr(shape != GrpAbandon && j == k - 1), 1'b0, '0);
          sent += 1 + k;
          // trailing neighbours start a fresh group on the same stored point
          if (shape == GrpTrailing) begin
            k = int'($urandom_range(1, 2));
            for (int j = 0; j < k; j++) send_beat(make_nbr(j == k - 1), 1'b0, '0);
            sent += k;
          end
        end
      endcase
    end
    // leave a group open so the next register write lands mid-group
    send_beat(make_query(1'b0), 1'b0, '0);
  endtask

  // Result side: check each beat against the oldest owed decision, stall at random,
  // and once hold off for a long stretch so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results <= n_results + 1;
        if (owed_rd == owed_wr) begin
          if (n_bad < MaxReports)
            $display("unexpected result: dec %0d pt %h %h %h", out_data_o.decision,
                     out_data_o.point_x, out_data_o.point_y, out_data_o.point_z);
          n_bad <= n_bad + 1;
        end else begin
          rx_want = owed[owed_rd % OwedDepth];
          owed_rd = owed_rd + 1;
          if (rx_want.decision !== out_data_o.decision ||
              rx_want.point_x  !== out_data_o.point_x  ||
              rx_want.point_y  !== out_data_o.point_y  ||
              rx_want.point_z  !== out_data_o.point_z) begin
            if (n_bad < MaxReports)
              $display("result %0d: want dec %0d pt %h %h %h, got dec %0d pt %h %h %h",
                       n_results, rx_want.decision, rx_want.point_x, rx_want.point_y,
                       rx_want.point_z, out_data_o.decision, out_data_o.point_x,
                       out_data_o.point_y, out_data_o.point_z);
            n_bad <= n_bad + 1;
          end
        end
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_hold = rx_burst ? 0 : int'($urandom_range(0, Gap));
        if (n_results == PressureAt) rx_hold = PressureHold;
        // keep ready high through a zero hold so it never drops and rises in one step
        if (rx_hold > 0) begin
          out_ready_i <= 1'b0;
          rx_wait     <= rx_hold - 1;
        end
      end else if (!out_ready_i) begin
        if (rx_wait == 0) out_ready_i <= 1'b1;
        else rx_wait <= rx_wait - 1;
      end
    end
  end

  initial begin
    logic [VoxelW-1:0] phase_size [NumPhases];
    held_pt        = '{default: '0};
    centre2        = '{default: 0};
    nbr_seen       = 1'b0;
    verdict_locked = 1'b0;
    verdict        = DecDown;
    // zero, both extremes, a few ordinary sizes, then back to the reset value
    phase_size = '{VoxelW'(0), VoxelW'(1), {VoxelW{1'b1}}, VoxelW'(65536),
                   VoxelW'($urandom_range(2, 1 << 20)), VoxelW'($urandom()), VoxelReset};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++)
      send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_voxel(phase_size[ph]);
      run_phase(RandItems / NumPhases);
    end
    drain();

    if (n_bad == 0 && owed_wr == owed_rd) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/vmif_pkg.sv
rtl/vmif_rem.sv
rtl/vmif_axis_chk.sv
rtl/voxel_map_insert_filter_top.sv
tb/testbench.sv
